[rtl/supply_voltage_supervisor_assert.svh]
// Assertion macros for the supply voltage supervisor.
// Uses clk and rst_n of the module that includes this header.
`ifndef SUPPLY_VOLTAGE_SUPERVISOR_ASSERT_SVH
`define SUPPLY_VOLTAGE_SUPERVISOR_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SVS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define SVS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/svs_pkg.sv]
// Shared types and constants of the supply voltage supervisor.
// No dependencies.
`timescale 1ns / 1ps

package svs_pkg;

    localparam int MV_W            = 16;
    localparam int TICK_W          = 16;
    localparam int CFG_IDX_W       = 4;
    localparam int COUNTER_BITS_DEF = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_COMM_HIGH     = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COMM_LOW      = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIAG_NORM_MAX = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DIAG_NORM_MIN = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DIAG_CRIT_MAX = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DIAG_CRIT_MIN = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TICKS    = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_FAULT_TICKS   = 4'd7;

    // reset values
    localparam logic [MV_W-1:0]   RST_COMM_HIGH     = 16'd18000;
    localparam logic [MV_W-1:0]   RST_COMM_LOW      = 16'd7000;
    localparam logic [MV_W-1:0]   RST_DIAG_NORM_MAX = 16'd16000;
    localparam logic [MV_W-1:0]   RST_DIAG_NORM_MIN = 16'd9000;
    localparam logic [MV_W-1:0]   RST_DIAG_CRIT_MAX = 16'd18000;
    localparam logic [MV_W-1:0]   RST_DIAG_CRIT_MIN = 16'd7000;
    localparam logic [TICK_W-1:0] RST_HOLD_TICKS    = 16'd20;
    localparam logic [TICK_W-1:0] RST_FAULT_TICKS   = 16'd50;

    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_HIGH   = 2'd1,
        MODE_LOW    = 2'd2
    } comm_mode_t;

    typedef enum logic [1:0] {
        CLASS_NORMAL   = 2'd0,
        CLASS_GENERAL  = 2'd1,
        CLASS_CRITICAL = 2'd2
    } diag_class_t;

    typedef struct packed {
        logic [MV_W-1:0]   comm_high_mv;
        logic [MV_W-1:0]   comm_low_mv;
        logic [MV_W-1:0]   diag_normal_max_mv;
        logic [MV_W-1:0]   diag_normal_min_mv;
        logic [MV_W-1:0]   diag_critical_max_mv;
        logic [MV_W-1:0]   diag_critical_min_mv;
        logic [TICK_W-1:0] hold_ticks;
        logic [TICK_W-1:0] fault_ticks;
    } svs_cfg_t;

    typedef struct packed {
        comm_mode_t mode;
        logic       active;
        logic       power_on_req;
        logic       tx_enable_req;
        logic       tx_disable_req;
    } comm_res_t;

    typedef struct packed {
        diag_class_t cls;
        logic        range_fault;
        logic        max_range_fault;
    } diag_res_t;

endpackage

[rtl/svs_sample_if.sv]
// Input channel: one supply sample word per handshake.
// Depends on svs_pkg.
`timescale 1ns / 1ps

interface svs_sample_if
    import svs_pkg::*;
();
    logic            valid;
    logic            ready;
    logic [MV_W-1:0] voltage_mv;
    logic            dtc_clear;

    modport source (output valid, output voltage_mv, output dtc_clear, input ready);
    modport sink   (input valid, input voltage_mv, input dtc_clear, output ready);
endinterface

[rtl/svs_result_if.sv]
// Output channel: one status word per handshake.
// Depends on nothing but its own signals.
`timescale 1ns / 1ps

interface svs_result_if;
    logic       valid;
    logic       ready;
    logic [1:0] comm_state;
    logic       comm_active;
    logic       power_on_request;
    logic       tx_enable_request;
    logic       tx_disable_request;
    logic [1:0] voltage_status;
    logic       over_range_fault;
    logic       over_max_range_fault;

    modport source (output valid, output comm_state, output comm_active,
                    output power_on_request, output tx_enable_request,
                    output tx_disable_request, output voltage_status,
                    output over_range_fault, output over_max_range_fault,
                    input ready);
    modport sink   (input valid, input comm_state, input comm_active,
                    input power_on_request, input tx_enable_request,
                    input tx_disable_request, input voltage_status,
                    input over_range_fault, input over_max_range_fault,
                    output ready);
endinterface

[rtl/svs_cfg_if.sv]
// Configuration write channel: register index and data word.
// Depends on svs_pkg.
`timescale 1ns / 1ps

interface svs_cfg_if
    import svs_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [MV_W-1:0]      data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/svs_cfg_regs.sv]
// Configuration register file with reset values.
// Depends on svs_pkg and svs_cfg_if.
`timescale 1ns / 1ps

module svs_cfg_regs
    import svs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    svs_cfg_if.sink   cfg_wr,
    output svs_cfg_t  cfg
);

    svs_cfg_t cfg_reg;
    svs_cfg_t cfg_next;
    logic     wr_en;

    assign cfg_wr.ready = 1'b1;
    assign wr_en        = cfg_wr.valid;
    assign cfg          = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (cfg_wr.index)
                CFG_COMM_HIGH:     cfg_next.comm_high_mv         = cfg_wr.data;
                CFG_COMM_LOW:      cfg_next.comm_low_mv          = cfg_wr.data;
                CFG_DIAG_NORM_MAX: cfg_next.diag_normal_max_mv   = cfg_wr.data;
                CFG_DIAG_NORM_MIN: cfg_next.diag_normal_min_mv   = cfg_wr.data;
                CFG_DIAG_CRIT_MAX: cfg_next.diag_critical_max_mv = cfg_wr.data;
                CFG_DIAG_CRIT_MIN: cfg_next.diag_critical_min_mv = cfg_wr.data;
                CFG_HOLD_TICKS:    cfg_next.hold_ticks           = cfg_wr.data;
                CFG_FAULT_TICKS:   cfg_next.fault_ticks          = cfg_wr.data;
                default:           cfg_next = cfg_reg; // unknown index ignored
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.comm_high_mv         <= RST_COMM_HIGH;
            cfg_reg.comm_low_mv          <= RST_COMM_LOW;
            cfg_reg.diag_normal_max_mv   <= RST_DIAG_NORM_MAX;
            cfg_reg.diag_normal_min_mv   <= RST_DIAG_NORM_MIN;
            cfg_reg.diag_critical_max_mv <= RST_DIAG_CRIT_MAX;
            cfg_reg.diag_critical_min_mv <= RST_DIAG_CRIT_MIN;
            cfg_reg.hold_ticks           <= RST_HOLD_TICKS;
            cfg_reg.fault_ticks          <= RST_FAULT_TICKS;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

[rtl/svs_comm_fsm.sv]
// Communication state machine with debounce and start/stop requests.
// Depends on svs_pkg.
`timescale 1ns / 1ps

module svs_comm_fsm
    import svs_pkg::*;
#(
    parameter int COUNTER_BITS = COUNTER_BITS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            step,
    input  logic [MV_W-1:0] voltage_mv,
    input  logic [MV_W-1:0] comm_high_mv,
    input  logic [MV_W-1:0] comm_low_mv,
    input  logic [TICK_W-1:0] hold_ticks,
    output comm_res_t       res
);

    localparam int CMP_W = (COUNTER_BITS > TICK_W) ? COUNTER_BITS : TICK_W;

    comm_mode_t              mode_reg, mode_next;
    comm_mode_t              pending_reg, pending_next;
    logic [COUNTER_BITS-1:0] count_reg, count_next;
    logic                    started_reg, started_next;
    logic                    powered_reg, powered_next;

    comm_mode_t              target;
    logic [COUNTER_BITS-1:0] count_inc;
    logic                    do_start;
    logic                    do_stop;
    logic                    pwr_req;
    logic                    txen_req;
    logic                    txdis_req;

    always_comb
    begin
        target = mode_reg;
        case (mode_reg)
            MODE_NORMAL:
            begin
                if (voltage_mv > comm_high_mv)
                    target = MODE_HIGH;
                else if (voltage_mv < comm_low_mv)
                    target = MODE_LOW;
            end
            MODE_HIGH:
            begin
                if (voltage_mv < comm_high_mv)
                    target = MODE_NORMAL;
            end
            default:
            begin
                if (voltage_mv > comm_low_mv)
                    target = MODE_NORMAL;
            end
        endcase
    end

    // saturating increment
    assign count_inc = (count_reg == '1) ? count_reg : count_reg + 1'b1;

    always_comb
    begin
        mode_next    = mode_reg;
        pending_next = pending_reg;
        count_next   = count_reg;
        do_start     = 1'b0;
        do_stop      = 1'b0;
        if (target != mode_reg)
        begin
            if (target != pending_reg)
            begin
                pending_next = target;
                count_next   = '0;
            end
            else if (CMP_W'(count_inc) >= CMP_W'(hold_ticks))
            begin
                mode_next  = target;
                count_next = '0;
                do_start   = (target == MODE_NORMAL);
                do_stop    = (target != MODE_NORMAL);
            end
            else
            begin
                count_next = count_inc;
            end
        end
        else
        begin
            count_next   = '0;
            pending_next = target;
            do_stop      = (mode_reg != MODE_NORMAL);
        end

        started_next = started_reg;
        powered_next = powered_reg;
        pwr_req      = 1'b0;
        txen_req     = 1'b0;
        txdis_req    = 1'b0;
        if (do_start && !started_reg)
        begin
            started_next = 1'b1;
            powered_next = 1'b1;
            pwr_req      = !powered_reg;
            txen_req     = powered_reg;
        end
        if (do_stop && started_reg)
        begin
            txdis_req    = 1'b1;
            started_next = 1'b0;
        end
    end

    assign res.mode           = mode_next;
    assign res.active         = started_next;
    assign res.power_on_req   = pwr_req;
    assign res.tx_enable_req  = txen_req;
    assign res.tx_disable_req = txdis_req;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_LOW;
            pending_reg <= MODE_LOW;
            count_reg   <= '0;
            started_reg <= 1'b0;
            powered_reg <= 1'b0;
        end
        else if (step)
        begin
            mode_reg    <= mode_next;
            pending_reg <= pending_next;
            count_reg   <= count_next;
            started_reg <= started_next;
            powered_reg <= powered_next;
        end
    end

endmodule

[rtl/svs_diag.sv]
// Diagnostic classifier with fault/recover counters and held fault flags.
// Depends on svs_pkg.
`timescale 1ns / 1ps

module svs_diag
    import svs_pkg::*;
#(
    parameter int COUNTER_BITS = COUNTER_BITS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            step,
    input  logic [MV_W-1:0] voltage_mv,
    input  logic            dtc_clear,
    input  svs_cfg_t        cfg,
    output diag_res_t       res
);

    localparam int CMP_W = (COUNTER_BITS > TICK_W) ? COUNTER_BITS : TICK_W;

    diag_class_t             last_reg, cls;
    logic [COUNTER_BITS-1:0] fault_reg, fault_next;
    logic [COUNTER_BITS-1:0] recover_reg, recover_next;
    logic                    range_reg, range_next;
    logic                    max_range_reg, max_range_next;
    logic [COUNTER_BITS-1:0] fc;
    logic [COUNTER_BITS-1:0] rc;

    // normal window first, then critical bounds
    always_comb
    begin
        if (voltage_mv >= cfg.diag_normal_min_mv && voltage_mv <= cfg.diag_normal_max_mv)
            cls = CLASS_NORMAL;
        else if (voltage_mv < cfg.diag_critical_min_mv ||
                 voltage_mv > cfg.diag_critical_max_mv)
            cls = CLASS_CRITICAL;
        else
            cls = CLASS_GENERAL;
    end

    always_comb
    begin
        fc             = (cls != last_reg) ? '0 : fault_reg;
        rc             = (cls != last_reg) ? '0 : recover_reg;
        fault_next     = fc;
        recover_next   = rc;
        range_next     = range_reg;
        max_range_next = max_range_reg;
        if (cls == CLASS_NORMAL)
        begin
            if (CMP_W'(rc) >= CMP_W'(cfg.fault_ticks))
            begin
                range_next     = 1'b0;
                max_range_next = 1'b0;
                recover_next   = '0;
            end
            else
            begin
                recover_next = (rc == '1) ? rc : rc + 1'b1;
            end
        end
        else
        begin
            fault_next = (fc == '1) ? fc : fc + 1'b1;
            if (CMP_W'(fault_next) >= CMP_W'(cfg.fault_ticks))
            begin
                if (cls == CLASS_CRITICAL)
                begin
                    max_range_next = 1'b1;
                    range_next     = 1'b0;
                end
                else
                begin
                    range_next = 1'b1;
                end
            end
        end
        // clear applies after the update, recover count untouched
        if (dtc_clear)
        begin
            fault_next     = '0;
            range_next     = 1'b0;
            max_range_next = 1'b0;
        end
    end

    assign res.cls             = cls;
    assign res.range_fault     = range_next;
    assign res.max_range_fault = max_range_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg      <= CLASS_NORMAL;
            fault_reg     <= '0;
            recover_reg   <= '0;
            range_reg     <= 1'b0;
            max_range_reg <= 1'b0;
        end
        else if (step)
        begin
            last_reg      <= cls;
            fault_reg     <= fault_next;
            recover_reg   <= recover_next;
            range_reg     <= range_next;
            max_range_reg <= max_range_next;
        end
    end

endmodule

[rtl/supply_voltage_supervisor.sv]
// Supply voltage supervisor: usage
//   sample_in  : one word per tick, voltage_mv (mV) and dtc_clear.
//   result_out : one status word per sample word, in order.
//   cfg_wr     : register writes (index 0..7, 16-bit data); always ready,
//                other indexes are dropped. Write only while the block is idle.
// Path: a sample accepted into the input register has its status word loaded
// into the result register and is offered on result_out from there
// (input register, then result register; all decision logic sits between).
// Throughput: one word per cycle while result_out.ready is high, as the input
// register advances whenever the result register is empty or being taken.
// Stall: when result_out.ready is low the result register holds its word;
// the input register still fills once, then sample_in.ready drops.
// Reset (rst_n low, async): both stages empty, registers to defaults,
// communication state low, link stopped, fault flags and counters clear.
`timescale 1ns / 1ps

module supply_voltage_supervisor
    import svs_pkg::*;
#(
    parameter int COUNTER_BITS = COUNTER_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    svs_sample_if.sink    sample_in,
    svs_result_if.source  result_out,
    svs_cfg_if.sink       cfg_wr
);

`include "supply_voltage_supervisor_assert.svh"

    svs_cfg_t        cfg;

    // input stage
    logic            in_valid_reg;
    logic [MV_W-1:0] in_mv_reg;
    logic            in_clr_reg;

    // result stage
    logic            out_valid_reg;
    comm_res_t       comm_res, comm_res_reg;
    diag_res_t       diag_res, diag_res_reg;

    logic            out_load;
    logic            step;

    // result register free or draining this cycle
    assign out_load        = !out_valid_reg || result_out.ready;
    // one sample word is processed and its state committed
    assign step            = in_valid_reg && out_load;
    assign sample_in.ready = !in_valid_reg || out_load;

    svs_cfg_regs u_cfg (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg_wr (cfg_wr),
        .cfg    (cfg)
    );

    svs_comm_fsm #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_comm (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .voltage_mv   (in_mv_reg),
        .comm_high_mv (cfg.comm_high_mv),
        .comm_low_mv  (cfg.comm_low_mv),
        .hold_ticks   (cfg.hold_ticks),
        .res          (comm_res)
    );

    svs_diag #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_diag (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .voltage_mv (in_mv_reg),
        .dtc_clear  (in_clr_reg),
        .cfg        (cfg),
        .res        (diag_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (sample_in.ready)
                in_valid_reg <= sample_in.valid;
            if (out_load)
                out_valid_reg <= in_valid_reg;
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (sample_in.valid && sample_in.ready)
        begin
            in_mv_reg  <= sample_in.voltage_mv;
            in_clr_reg <= sample_in.dtc_clear;
        end
        if (step)
        begin
            comm_res_reg <= comm_res;
            diag_res_reg <= diag_res;
        end
    end

    assign result_out.valid                = out_valid_reg;
    assign result_out.comm_state           = comm_res_reg.mode;
    assign result_out.comm_active          = comm_res_reg.active;
    assign result_out.power_on_request     = comm_res_reg.power_on_req;
    assign result_out.tx_enable_request    = comm_res_reg.tx_enable_req;
    assign result_out.tx_disable_request   = comm_res_reg.tx_disable_req;
    assign result_out.voltage_status       = diag_res_reg.cls;
    assign result_out.over_range_fault     = diag_res_reg.range_fault;
    assign result_out.over_max_range_fault = diag_res_reg.max_range_fault;

    // a live link only exists in the normal state
    `SVS_ASSERT_NOW(a_active_in_normal, out_valid_reg && comm_res_reg.active,
        comm_res_reg.mode == MODE_NORMAL, "link active outside normal state")

    // a start request leaves the link active, a stop request leaves it idle
    `SVS_ASSERT_NOW(a_start_active,
        out_valid_reg && (comm_res_reg.power_on_req || comm_res_reg.tx_enable_req),
        comm_res_reg.active && !comm_res_reg.tx_disable_req,
        "start request without active link")

    `SVS_ASSERT_NOW(a_stop_idle, out_valid_reg && comm_res_reg.tx_disable_req,
        !comm_res_reg.active, "stop request with link still active")

    // a processed word always lands in the result register
    `SVS_ASSERT_NEXT(a_step_lands, step, out_valid_reg, "processed word lost")

endmodule

[dv/supply_voltage_supervisor_tb.sv]
// Self-checking testbench for the supply voltage supervisor: random and directed
// sample words, an in-bench predictor and an in-order check of every status word.
// Depends on svs_pkg, the three channel interfaces and the supervisor RTL.
`timescale 1ns / 1ps

module supply_voltage_supervisor_tb;
    import svs_pkg::*;

    localparam int CLK_PERIOD  = 10;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int MAX_PRINTS  = 40;
    localparam int CNT_W       = COUNTER_BITS_DEF;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;
    localparam int TAIL_WORDS  = 40;
    localparam int HOLD_OFF_CYCLES = 300;

    // indexes outside the register map; writes to them must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 4'd8;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 4'd15;

    typedef struct packed {
        logic [MV_W-1:0] voltage_mv;
        logic            dtc_clear;
    } sample_word_t;

    typedef struct packed {
        comm_res_t comm;
        diag_res_t diag;
    } status_word_t;

    logic clk;
    logic rst_n;

    svs_sample_if smp ();
    svs_result_if res ();
    svs_cfg_if    cfg ();

    supply_voltage_supervisor dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample_in  (smp),
        .result_out (res),
        .cfg_wr     (cfg)
    );

    // ------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------
    sample_word_t pending_words[$];   // sample words not yet offered
    status_word_t status_expect[$];   // predicted status words, oldest first

    logic        sample_fire  = 1'b0; // sample word taken at the last rising edge
    logic        full_rate    = 1'b0; // no idling on either side
    logic        hold_off     = 1'b0; // long receiver stall in progress
    logic        pressure_armed = 1'b0;
    int unsigned send_gap     = 0;
    int unsigned recv_stall   = 0;
    int unsigned words_checked = 0;
    int unsigned reg_writes   = 0;
    int unsigned fail_count   = 0;
    int unsigned cycles       = 0;

    // predictor copy of the registers and the supervisor state
    svs_cfg_t          model_cfg;
    comm_mode_t        model_mode;
    comm_mode_t        model_pending;
    logic [CNT_W-1:0]  model_change_cnt;
    logic              model_started;
    logic              model_powered;
    diag_class_t       model_last_cls;
    logic [CNT_W-1:0]  model_fault_cnt;
    logic [CNT_W-1:0]  model_recover_cnt;
    logic              model_range_flag;
    logic              model_max_flag;

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic logic [CNT_W-1:0] sat_step(logic [CNT_W-1:0] c);
        return (c == CNT_MAX) ? c : c + 1'b1;
    endfunction

    // Advances the predicted state by one sample word and returns the status
    // word the block should produce for it.
    function automatic status_word_t predict_status(logic [MV_W-1:0] v, logic clr);
        status_word_t w;
        comm_mode_t   target;
        diag_class_t  cls;
        logic         start_link;
        logic         stop_link;
        w = '0;
        target = model_mode;
        start_link = 1'b0;
        stop_link = 1'b0;

        // hysteresis: the threshold that gets you out differs per state
        case (model_mode)
            MODE_NORMAL:
            begin
                if (v > model_cfg.comm_high_mv)
                    target = MODE_HIGH;
                else if (v < model_cfg.comm_low_mv)
                    target = MODE_LOW;
            end
            MODE_HIGH:
            begin
                if (v < model_cfg.comm_high_mv)
                    target = MODE_NORMAL;
            end
            default:
            begin
                if (v > model_cfg.comm_low_mv)
                    target = MODE_NORMAL;
            end
        endcase

        // debounce: first word naming a new target only arms it
        if (target != model_mode)
        begin
            if (target != model_pending)
            begin
                model_pending = target;
                model_change_cnt = '0;
            end
            else
            begin
                model_change_cnt = sat_step(model_change_cnt);
                if (model_change_cnt >= model_cfg.hold_ticks)
                begin
                    model_mode = target;
                    model_change_cnt = '0;
                    if (target == MODE_NORMAL)
                        start_link = 1'b1;
                    else
                        stop_link = 1'b1;
                end
            end
        end
        else
        begin
            model_change_cnt = '0;
            model_pending = target;
            // staying high or low keeps pushing the link down
            if (model_mode != MODE_NORMAL)
                stop_link = 1'b1;
        end

        if (start_link && !model_started)
        begin
            model_started = 1'b1;
            if (!model_powered)
            begin
                model_powered = 1'b1;
                w.comm.power_on_req = 1'b1;
            end
            else
            begin
                w.comm.tx_enable_req = 1'b1;
            end
        end
        if (stop_link && model_started)
        begin
            w.comm.tx_disable_req = 1'b1;
            model_started = 1'b0;
        end

        // normal window wins over critical bounds when they overlap
        if (v >= model_cfg.diag_normal_min_mv && v <= model_cfg.diag_normal_max_mv)
            cls = CLASS_NORMAL;
        else if (v < model_cfg.diag_critical_min_mv || v > model_cfg.diag_critical_max_mv)
            cls = CLASS_CRITICAL;
        else
            cls = CLASS_GENERAL;

        if (cls != model_last_cls)
        begin
            model_fault_cnt = '0;
            model_recover_cnt = '0;
            model_last_cls = cls;
        end

        if (cls == CLASS_NORMAL)
        begin
            if (model_recover_cnt >= model_cfg.fault_ticks)
            begin
                model_range_flag = 1'b0;
                model_max_flag = 1'b0;
                model_recover_cnt = '0;
            end
            else
            begin
                model_recover_cnt = sat_step(model_recover_cnt);
            end
        end
        else
        begin
            model_fault_cnt = sat_step(model_fault_cnt);
            if (model_fault_cnt >= model_cfg.fault_ticks)
            begin
                if (cls == CLASS_CRITICAL)
                begin
                    model_max_flag = 1'b1;
                    model_range_flag = 1'b0;
                end
                else
                begin
                    model_range_flag = 1'b1;
                end
            end
        end

        // clear comes last and leaves the recover count alone
        if (clr)
        begin
            model_fault_cnt = '0;
            model_range_flag = 1'b0;
            model_max_flag = 1'b0;
        end

        w.comm.mode = model_mode;
        w.comm.active = model_started;
        w.diag.cls = cls;
        w.diag.range_fault = model_range_flag;
        w.diag.max_range_fault = model_max_flag;
        return w;
    endfunction

    // ------------------------------------------------------------------
    // Reporting
    // ------------------------------------------------------------------
    task automatic report(string msg);
        if (fail_count < MAX_PRINTS)
            $display("mismatch @%0t: %s", $time, msg);
        fail_count++;
    endtask

    task automatic check_field(string name, logic [15:0] got, logic [15:0] want_v);
        if (got !== want_v)
            report($sformatf("status word %0d: %s is %0d, predicted %0d",
                             words_checked, name, got, want_v));
    endtask

    // ------------------------------------------------------------------
    // Idle lengths: mostly none or short, now and then long.
    // full_rate gives stretches with no idling at all.
    // ------------------------------------------------------------------
    function automatic int unsigned draw_idle();
        int unsigned r;
        if (full_rate)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 2);
        else if (r < 97)
            return $urandom_range(3, 8);
        return $urandom_range(15, 50);
    endfunction

    // ------------------------------------------------------------------
    // Monitor: everything sampled at the rising edge.
    // Register writes and sample words update the predictor when taken;
    // status words are compared against the oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        status_word_t want;
        if (rst_n)
        begin
            sample_fire <= smp.valid && smp.ready;

            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    CFG_COMM_HIGH:     model_cfg.comm_high_mv = cfg.data;
                    CFG_COMM_LOW:      model_cfg.comm_low_mv = cfg.data;
                    CFG_DIAG_NORM_MAX: model_cfg.diag_normal_max_mv = cfg.data;
                    CFG_DIAG_NORM_MIN: model_cfg.diag_normal_min_mv = cfg.data;
                    CFG_DIAG_CRIT_MAX: model_cfg.diag_critical_max_mv = cfg.data;
                    CFG_DIAG_CRIT_MIN: model_cfg.diag_critical_min_mv = cfg.data;
                    CFG_HOLD_TICKS:    model_cfg.hold_ticks = cfg.data;
                    CFG_FAULT_TICKS:   model_cfg.fault_ticks = cfg.data;
                    default: ;
                endcase
                reg_writes <= reg_writes + 1;
            end

            if (smp.valid && smp.ready)
                status_expect.push_back(predict_status(smp.voltage_mv, smp.dtc_clear));

            if (res.valid && res.ready)
            begin
                if (status_expect.size() == 0)
                begin
                    report("status word with no sample word outstanding");
                end
                else
                begin
                    want = status_expect.pop_front();
                    check_field("comm_state", 16'(res.comm_state), 16'(want.comm.mode));
                    check_field("comm_active", 16'(res.comm_active),
                                16'(want.comm.active));
                    check_field("power_on_request", 16'(res.power_on_request),
                                16'(want.comm.power_on_req));
                    check_field("tx_enable_request", 16'(res.tx_enable_request),
                                16'(want.comm.tx_enable_req));
                    check_field("tx_disable_request", 16'(res.tx_disable_request),
                                16'(want.comm.tx_disable_req));
                    check_field("voltage_status", 16'(res.voltage_status),
                                16'(want.diag.cls));
                    check_field("over_range_fault", 16'(res.over_range_fault),
                                16'(want.diag.range_fault));
                    check_field("over_max_range_fault", 16'(res.over_max_range_fault),
                                16'(want.diag.max_range_fault));
                end
                words_checked <= words_checked + 1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sample driver and result receiver, both at the falling edge.
    // A word stays on the bus until taken; a gap is drawn after each word.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        sample_word_t word;
        if (rst_n)
        begin
            if (!smp.valid || sample_fire)
            begin
                if (send_gap > 0)
                begin
                    smp.valid <= 1'b0;
                    send_gap <= send_gap - 1;
                end
                else if (pending_words.size() > 0)
                begin
                    word = pending_words.pop_front();
                    smp.valid <= 1'b1;
                    smp.voltage_mv <= word.voltage_mv;
                    smp.dtc_clear <= word.dtc_clear;
                    send_gap <= draw_idle();
                end
                else
                begin
                    smp.valid <= 1'b0;
                end
            end

            // long hold-off overrides the random stalls
            if (hold_off)
            begin
                res.ready <= 1'b0;
            end
            else if (recv_stall > 0)
            begin
                res.ready <= 1'b0;
                recv_stall <= recv_stall - 1;
            end
            else
            begin
                res.ready <= 1'b1;
                recv_stall <= draw_idle();
            end
        end
    end

    // Backpressure: once armed, the receiver refuses status words for a long
    // stretch while the driver keeps offering, so the input side must stall.
    initial
    begin
        while (!pressure_armed)
            @(posedge clk);
        repeat (5) @(posedge clk);
        hold_off = 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off = 1'b0;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_sample(logic [MV_W-1:0] v, logic clr);
        sample_word_t w;
        w.voltage_mv = v;
        w.dtc_clear = clr;
        pending_words.push_back(w);
    endtask

    // One register write; valid is raised and dropped on different falling edges.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [MV_W-1:0] data);
        int unsigned target;
        target = reg_writes + 1;
        @(negedge clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= data;
        do
            @(negedge clk);
        while (reg_writes != target);
        cfg.valid <= 1'b0;
    endtask

    task automatic load_config(svs_cfg_t c);
        write_reg(CFG_COMM_HIGH, c.comm_high_mv);
        write_reg(CFG_COMM_LOW, c.comm_low_mv);
        write_reg(CFG_DIAG_NORM_MAX, c.diag_normal_max_mv);
        write_reg(CFG_DIAG_NORM_MIN, c.diag_normal_min_mv);
        write_reg(CFG_DIAG_CRIT_MAX, c.diag_critical_max_mv);
        write_reg(CFG_DIAG_CRIT_MIN, c.diag_critical_min_mv);
        write_reg(CFG_HOLD_TICKS, c.hold_ticks);
        write_reg(CFG_FAULT_TICKS, c.fault_ticks);
    endtask

    // Block is idle once nothing is queued, offered or outstanding. Every
    // sample word yields a status word, so a short pause covers the pipe.
    task automatic wait_idle();
        while (pending_words.size() != 0 || smp.valid || status_expect.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Mostly a sane window layout, sometimes anything (overlapping windows).
    function automatic svs_cfg_t draw_config();
        svs_cfg_t    c;
        int unsigned b;
        int unsigned r;
        if ($urandom_range(0, 9) < 7)
        begin
            b = $urandom_range(0, 15000);
            c.diag_critical_min_mv = MV_W'(b);
            c.diag_normal_min_mv = MV_W'(b + $urandom_range(0, 8000));
            c.diag_normal_max_mv = MV_W'(c.diag_normal_min_mv + $urandom_range(0, 10000));
            c.diag_critical_max_mv = MV_W'(c.diag_normal_max_mv + $urandom_range(0, 8000));
            c.comm_low_mv = MV_W'(c.diag_critical_min_mv + $urandom_range(0, 3000));
            c.comm_high_mv = MV_W'(c.diag_normal_max_mv + $urandom_range(0, 3000));
        end
        else
        begin
            c.comm_high_mv = MV_W'($urandom);
            c.comm_low_mv = MV_W'($urandom);
            c.diag_normal_max_mv = MV_W'($urandom);
            c.diag_normal_min_mv = MV_W'($urandom);
            c.diag_critical_max_mv = MV_W'($urandom);
            c.diag_critical_min_mv = MV_W'($urandom);
        end
        r = $urandom_range(0, 9);
        c.hold_ticks = TICK_W'((r < 7) ? $urandom_range(0, 6) : $urandom_range(7, 30));
        r = $urandom_range(0, 9);
        c.fault_ticks = TICK_W'((r < 7) ? $urandom_range(0, 8) : $urandom_range(9, 40));
        return c;
    endfunction

    // Voltage level: mostly right at one of the current thresholds, so both
    // sides of every compare get hit; some full-range values and extremes.
    function automatic logic [MV_W-1:0] draw_level();
        logic [MV_W-1:0] base;
        case ($urandom_range(0, 9))
            0: return MV_W'($urandom);
            1: return ($urandom_range(0, 1) == 0) ? 16'h0000 : 16'hFFFF;
            2: base = model_cfg.comm_high_mv;
            3: base = model_cfg.comm_low_mv;
            4: base = model_cfg.diag_normal_max_mv;
            5: base = model_cfg.diag_normal_min_mv;
            6: base = model_cfg.diag_critical_max_mv;
            default: base = model_cfg.diag_critical_min_mv;
        endcase
        return MV_W'(base + $urandom_range(0, 4) - 2);
    endfunction

    // Runs of one level long enough to get through the debounce, with
    // short runs and jitter as noise that restarts the count.
    task automatic queue_random_phase(int unsigned n_words);
        logic [MV_W-1:0] level;
        logic [MV_W-1:0] v;
        int unsigned     run;
        int unsigned     hold;
        int unsigned     n;
        n = 0;
        while (n < n_words)
        begin
            level = draw_level();
            hold = 32'(model_cfg.hold_ticks);
            if ($urandom_range(0, 9) < 3)
                run = $urandom_range(1, 3);
            else if (hold <= 40)
                run = $urandom_range(hold + 1, hold + 4);
            else
                run = $urandom_range(1, 8);
            repeat (run)
            begin
                v = level;
                if ($urandom_range(0, 9) == 0)
                    v = MV_W'(level + $urandom_range(0, 64) - 32);
                queue_sample(v, $urandom_range(0, 19) == 0);
                n++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        svs_cfg_t c;
        int       p;

        // all block inputs known from time zero
        smp.valid = 1'b0;
        smp.voltage_mv = '0;
        smp.dtc_clear = 1'b0;
        res.ready = 1'b0;
        cfg.valid = 1'b0;
        cfg.index = '0;
        cfg.data = '0;

        model_cfg.comm_high_mv = RST_COMM_HIGH;
        model_cfg.comm_low_mv = RST_COMM_LOW;
        model_cfg.diag_normal_max_mv = RST_DIAG_NORM_MAX;
        model_cfg.diag_normal_min_mv = RST_DIAG_NORM_MIN;
        model_cfg.diag_critical_max_mv = RST_DIAG_CRIT_MAX;
        model_cfg.diag_critical_min_mv = RST_DIAG_CRIT_MIN;
        model_cfg.hold_ticks = RST_HOLD_TICKS;
        model_cfg.fault_ticks = RST_FAULT_TICKS;
        model_mode = MODE_LOW;
        model_pending = MODE_LOW;
        model_change_cnt = '0;
        model_started = 1'b0;
        model_powered = 1'b0;
        model_last_cls = CLASS_NORMAL;
        model_fault_cnt = '0;
        model_recover_cnt = '0;
        model_range_flag = 1'b0;
        model_max_flag = 1'b0;

        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(posedge clk);

        // Reset registers: field extremes and each threshold and its neighbor.
        queue_sample(16'd0, 1'b0);
        queue_sample(16'hFFFF, 1'b1);
        queue_sample(16'd7000, 1'b0);
        queue_sample(16'd7001, 1'b0);
        queue_sample(16'd18000, 1'b0);
        queue_sample(16'd18001, 1'b0);
        queue_sample(16'd8999, 1'b0);
        queue_sample(16'd9000, 1'b1);
        queue_sample(16'd16000, 1'b0);
        queue_sample(16'd16001, 1'b0);
        wait_idle();

        // Zero hold and zero fault ticks; writes to unmapped indexes are dropped.
        write_reg(CFG_HOLD_TICKS, '0);
        write_reg(CFG_FAULT_TICKS, '0);
        write_reg(CFG_UNUSED_LO, '0);
        write_reg(CFG_UNUSED_HI, '1);
        queue_sample(16'd8000, 1'b0);   // takes normal at once: power-on pulse; general class sets flag
        queue_sample(16'd8000, 1'b0);   // already normal: no request
        queue_sample(16'd20000, 1'b0);  // critical after general
        queue_sample(16'd20000, 1'b0);  // high: link stops
        queue_sample(16'd12000, 1'b0);  // normal class clears both flags at once
        queue_sample(16'd12000, 1'b1);  // second start: transmit enable
        queue_sample(16'd3000, 1'b0);
        queue_sample(16'd3000, 1'b1);   // clear lands after the flag update
        queue_sample(16'd17000, 1'b0);  // arms normal
        queue_sample(16'd5000, 1'b0);   // back on current state: count restarts
        queue_sample(16'd17000, 1'b0);
        queue_sample(16'd17000, 1'b0);
        wait_idle();

        // Random phases, each under its own register set.
        for (p = 0; p < 8; p++)
        begin
            if (p == 2)
            begin
                c = '0;
                c.fault_ticks = '1;
            end
            else if (p == 5)
            begin
                c = '1;
                c.fault_ticks = '0;
            end
            else
            begin
                c = draw_config();
            end
            load_config(c);
            full_rate = ($urandom_range(0, 3) == 0);
            if (p == 3)
            begin
                queue_random_phase(120);
                pressure_armed = 1'b1;
            end
            else
            begin
                queue_random_phase(80);
            end
            wait_idle();
        end
        full_rate = 1'b0;

        // Long tick counts: with hold and fault ticks at the counter maximum
        // a short run of out-of-range words changes neither state nor flags.
        c.comm_high_mv = 16'd40000;
        c.comm_low_mv = 16'd20000;
        c.diag_normal_max_mv = 16'd35000;
        c.diag_normal_min_mv = 16'd25000;
        c.diag_critical_max_mv = 16'd60000;
        c.diag_critical_min_mv = 16'd10000;
        c.hold_ticks = '0;
        c.fault_ticks = '0;
        load_config(c);
        queue_sample(16'd30000, 1'b0);  // settle into normal from any state
        queue_sample(16'd30000, 1'b0);
        wait_idle();
        write_reg(CFG_HOLD_TICKS, '1);
        write_reg(CFG_FAULT_TICKS, '1);
        full_rate = 1'b1;
        repeat (TAIL_WORDS) queue_sample(16'hFFFF, 1'b0);
        wait_idle();

        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
